>>> design/piq_pkg.sv
// shared types and constants of the pts interpolation queue
package piq_pkg;

   localparam int TIME_W = 48;
   localparam int DUR_W  = 47;
   localparam int ALU_W  = 50;
   localparam int DIFF_W = 49;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DUE,
      ST_ADD,
      ST_POP_RD,
      ST_POP_CHK,
      ST_SINCE,
      ST_MIN,
      ST_SUM,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic signed [TIME_W-1:0] pts;
      logic signed [TIME_W-1:0] due;
      logic [DUR_W-1:0]         length;
   } entry_type;

   typedef struct packed {
      logic signed [ALU_W-1:0] a;
      logic signed [ALU_W-1:0] b;
      logic                    sub;
   } alu_req_type;

endpackage

>>> design/piq_mem.sv
// entry storage of the queue, one write and one registered read port
module piq_mem #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  piq_pkg::entry_type    wr_data,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output piq_pkg::entry_type    rd_data
);

   piq_pkg::entry_type mem [DEPTH];
   piq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/piq_alu.sv
// shared add, subtract and compare unit with 48-bit saturation
module piq_alu (
   input  piq_pkg::alu_req_type                 req,
   output logic signed [piq_pkg::ALU_W-1:0]     sum,
   output logic signed [piq_pkg::TIME_W-1:0]    sat
);

   logic signed [piq_pkg::ALU_W-1:0] b_eff;

   always_comb begin
      b_eff = req.sub ? ~req.b : req.b;
      sum   = req.a + b_eff + piq_pkg::ALU_W'(req.sub);
      if ((sum[piq_pkg::ALU_W-1] == sum[piq_pkg::TIME_W-1])
          && (sum[piq_pkg::ALU_W-2] == sum[piq_pkg::TIME_W-1])) begin
         sat = sum[piq_pkg::TIME_W-1:0];
      end else if (sum[piq_pkg::ALU_W-1]) begin
         sat = {1'b1, {(piq_pkg::TIME_W-1){1'b0}}};
      end else begin
         sat = {1'b0, {(piq_pkg::TIME_W-1){1'b1}}};
      end
   end

endmodule

>>> design/pts_interpolation_queue.sv
// top level: sequencer, queue state and stream ports of the pts interpolation queue
//
// channel  dir  tdata                                        tuser
// req      in   pts[47:0] delay[95:48] duration[142:96]      flush[0] add[1]
//               now[190:143], zero pad [191]
// rsp      out  playing_pts[47:0]                            pts_valid[0] overflow[1]
//
// an item runs through the due and add steps when add is set, then the pop loop, then the
// since step, the min and sum steps when it interpolates, and the output step; the pop
// loop takes one memory read and one compare in the shared unit per entry.
// reset clears the queue, the current entry and the result valid flag at once.
// req_tready is high only between items; a result waits in its register while the
// next item is taken, and a stalled rsp side holds the block at its final step.
module pts_interpolation_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [191:0] req_tdata,   // pts, delay, duration, now, pad
   input  logic [1:0]   req_tuser,   // flush, add
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,   // playing_pts
   output logic [1:0]   rsp_tuser    // pts_valid, overflow
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int TW = piq_pkg::TIME_W;
   localparam int LW = piq_pkg::ALU_W;
   localparam int DW = piq_pkg::DIFF_W;

   piq_pkg::state_type state_ff, state_in;
   logic [AW-1:0]   head_ff, head_in;
   logic [CW-1:0]   fill_ff, fill_in;
   logic            cur_valid_ff, cur_valid_in;
   logic signed [TW-1:0] cur_pts_ff, cur_pts_in;
   logic signed [TW-1:0] cur_due_ff, cur_due_in;
   logic [piq_pkg::DUR_W-1:0] cur_len_ff, cur_len_in;
   logic signed [TW-1:0] pts_ff, pts_in;
   logic signed [TW-1:0] delay_ff, delay_in;
   logic [piq_pkg::DUR_W-1:0] dur_ff, dur_in;
   logic signed [TW-1:0] now_ff, now_in;
   logic signed [TW-1:0] due_ff, due_in;
   logic signed [DW-1:0] since_ff, since_in;
   logic signed [DW-1:0] step_ff, step_in;
   logic signed [TW-1:0] res_ff, res_in;
   logic            ovf_ff, ovf_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [TW-1:0]   rsp_pts_ff, rsp_pts_in;
   logic            rsp_pv_ff, rsp_pv_in;
   logic            rsp_ovf_ff, rsp_ovf_in;

   logic [CW:0]     tail_sum, wr_sum;
   logic [AW-1:0]   tail_idx, wr_idx, head_next;
   logic            wr_en, rd_en;
   logic [AW-1:0]   rd_addr;
   piq_pkg::entry_type wr_data, rd_data;
   piq_pkg::alu_req_type alu_req;
   logic signed [LW-1:0] alu_sum;
   logic signed [TW-1:0] alu_sat;
   logic            dup;

   piq_mem #(
      .DEPTH (QUEUE_DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   piq_alu u_alu (
      .req (alu_req),
      .sum (alu_sum),
      .sat (alu_sat)
   );

   always_comb begin
      tail_sum = (CW+1)'(head_ff) + (CW+1)'(fill_ff) - (CW+1)'(1);
      if (tail_sum >= (CW+1)'(QUEUE_DEPTH)) begin
         tail_sum = tail_sum - (CW+1)'(QUEUE_DEPTH);
      end
      tail_idx = tail_sum[AW-1:0];
      wr_sum = (CW+1)'(head_ff) + (CW+1)'(fill_ff);
      if (wr_sum >= (CW+1)'(QUEUE_DEPTH)) begin
         wr_sum = wr_sum - (CW+1)'(QUEUE_DEPTH);
      end
      wr_idx = wr_sum[AW-1:0];
      if (head_ff == AW'(QUEUE_DEPTH - 1)) begin
         head_next = '0;
      end else begin
         head_next = head_ff + AW'(1);
      end
   end

   assign wr_data = '{pts: pts_ff, due: due_ff, length: dur_ff};
   assign req_tready = (state_ff == piq_pkg::ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      cur_valid_in = cur_valid_ff;
      cur_pts_in   = cur_pts_ff;
      cur_due_in   = cur_due_ff;
      cur_len_in   = cur_len_ff;
      pts_in       = pts_ff;
      delay_in     = delay_ff;
      dur_in       = dur_ff;
      now_in       = now_ff;
      due_in       = due_ff;
      since_in     = since_ff;
      step_in      = step_ff;
      res_in       = res_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_pts_in   = rsp_pts_ff;
      rsp_pv_in    = rsp_pv_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = head_ff;
      alu_req      = '0;
      dup          = 1'b0;

      unique case (state_ff)
         piq_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               pts_in   = req_tdata[47:0];
               delay_in = req_tdata[95:48];
               dur_in   = req_tdata[142:96];
               now_in   = req_tdata[190:143];
               ovf_in   = 1'b0;
               if (req_tuser[0]) begin
                  head_in      = '0;
                  fill_in      = '0;
                  cur_valid_in = 1'b0;
                  cur_pts_in   = '0;
                  cur_due_in   = '0;
                  cur_len_in   = '0;
               end
               state_in = req_tuser[1] ? piq_pkg::ST_DUE : piq_pkg::ST_POP_RD;
            end
         end
         piq_pkg::ST_DUE: begin
            alu_req.a   = {{(LW-TW){now_ff[TW-1]}}, now_ff};
            alu_req.b   = {{(LW-TW){delay_ff[TW-1]}}, delay_ff};
            alu_req.sub = 1'b0;
            due_in      = alu_sat;
            rd_en       = 1'b1;
            rd_addr     = tail_idx;
            state_in    = piq_pkg::ST_ADD;
         end
         piq_pkg::ST_ADD: begin
            if (fill_ff != '0) begin
               dup = (rd_data.pts == pts_ff);
            end else begin
               dup = cur_valid_ff && (cur_pts_ff == pts_ff);
            end
            if (!dup) begin
               if ((fill_ff == '0) && !cur_valid_ff) begin
                  cur_pts_in   = pts_ff;
                  cur_due_in   = due_ff;
                  cur_len_in   = dur_ff;
                  cur_valid_in = 1'b1;
               end else if (fill_ff == CW'(QUEUE_DEPTH)) begin
                  ovf_in = 1'b1;
               end else begin
                  wr_en   = 1'b1;
                  fill_in = fill_ff + CW'(1);
               end
            end
            state_in = piq_pkg::ST_POP_RD;
         end
         piq_pkg::ST_POP_RD: begin
            rd_en   = 1'b1;
            rd_addr = head_ff;
            state_in = (fill_ff == '0) ? piq_pkg::ST_SINCE : piq_pkg::ST_POP_CHK;
         end
         piq_pkg::ST_POP_CHK: begin
            alu_req.a   = {{(LW-TW){now_ff[TW-1]}}, now_ff};
            alu_req.b   = {{(LW-TW){rd_data.due[TW-1]}}, rd_data.due};
            alu_req.sub = 1'b1;
            if (!cur_valid_ff || !alu_sum[LW-1]) begin
               cur_pts_in   = rd_data.pts;
               cur_due_in   = rd_data.due;
               cur_len_in   = rd_data.length;
               cur_valid_in = 1'b1;
               head_in      = head_next;
               fill_in      = fill_ff - CW'(1);
               state_in     = piq_pkg::ST_POP_RD;
            end else begin
               state_in = piq_pkg::ST_SINCE;
            end
         end
         piq_pkg::ST_SINCE: begin
            alu_req.a   = {{(LW-TW){now_ff[TW-1]}}, now_ff};
            alu_req.b   = {{(LW-TW){cur_due_ff[TW-1]}}, cur_due_ff};
            alu_req.sub = 1'b1;
            since_in    = alu_sum[DW-1:0];
            if (!cur_valid_ff) begin
               res_in   = '0;
               state_in = piq_pkg::ST_OUT;
            end else if (cur_due_ff == '0) begin
               res_in   = cur_pts_ff;
               state_in = piq_pkg::ST_OUT;
            end else begin
               state_in = piq_pkg::ST_MIN;
            end
         end
         piq_pkg::ST_MIN: begin
            alu_req.a   = {{(LW-piq_pkg::DUR_W){1'b0}}, cur_len_ff};
            alu_req.b   = {{(LW-DW){since_ff[DW-1]}}, since_ff};
            alu_req.sub = 1'b1;
            if (alu_sum[LW-1]) begin
               step_in = {{(DW-piq_pkg::DUR_W){1'b0}}, cur_len_ff};
            end else begin
               step_in = since_ff;
            end
            state_in = piq_pkg::ST_SUM;
         end
         piq_pkg::ST_SUM: begin
            alu_req.a   = {{(LW-TW){cur_pts_ff[TW-1]}}, cur_pts_ff};
            alu_req.b   = {{(LW-DW){step_ff[DW-1]}}, step_ff};
            alu_req.sub = 1'b0;
            res_in      = alu_sat;
            state_in    = piq_pkg::ST_OUT;
         end
         piq_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_pts_in   = res_ff;
               rsp_pv_in    = cur_valid_ff;
               rsp_ovf_in   = ovf_ff;
               state_in     = piq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = piq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= piq_pkg::ST_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         cur_valid_ff <= 1'b0;
         cur_pts_ff   <= '0;
         cur_due_ff   <= '0;
         cur_len_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         cur_valid_ff <= cur_valid_in;
         cur_pts_ff   <= cur_pts_in;
         cur_due_ff   <= cur_due_in;
         cur_len_ff   <= cur_len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pts_ff     <= pts_in;
      delay_ff   <= delay_in;
      dur_ff     <= dur_in;
      now_ff     <= now_in;
      due_ff     <= due_in;
      since_ff   <= since_in;
      step_ff    <= step_in;
      res_ff     <= res_in;
      ovf_ff     <= ovf_in;
      rsp_pts_ff <= rsp_pts_in;
      rsp_pv_ff  <= rsp_pv_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pts_ff;
   assign rsp_tuser  = {rsp_ovf_ff, rsp_pv_ff};

`ifndef NO_ASSERTIONS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(QUEUE_DEPTH))
      else $error("queue fill above depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == piq_pkg::ST_POP_CHK) |-> (fill_ff != '0))
      else $error("head check on empty queue");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("item taken while busy");

   a_no_pts_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("pts reported without current entry");

   a_overflow_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> rsp_tuser[0])
      else $error("overflow without current entry");
`endif

endmodule
